// ----- design/crcf_pkg.sv -----
// Shared constants, types and state codes of the framed CRC-8 command finder.
// No dependencies; the CRC unit and the top level import this package.
package crcf_pkg;

    localparam int PKT_LEN = 20;
    localparam int IDX_W   = $clog2(PKT_LEN);
    localparam int FILL_W  = $clog2(PKT_LEN + 1);

    localparam logic [7:0] HDR_FIRST   = 8'hAA;
    localparam logic [7:0] HDR_SECOND  = 8'hCC;
    localparam logic [7:0] FOOTER_BYTE = 8'hEE;
    localparam logic [7:0] CRC_POLY    = 8'h07;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CRC   = 5'b00010,
        S_CHECK = 5'b00100,
        S_EMIT  = 5'b01000,
        S_MISS  = 5'b10000
    } t_state;

    // Control of the shared CRC unit
    typedef struct packed {
        logic clr;
        logic en;
    } t_crc_ctrl;

endpackage

// ----- design/crcf_if.sv -----
// Valid/ready channel interfaces for received bytes and for results.
// Depends on nothing; used by the top level of the command finder.
interface crcf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface crcf_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] packet_byte;
    logic       last_of_run;

    modport source (output valid, output found, output packet_byte, output last_of_run,
                    input ready);
    modport sink   (input valid, input found, input packet_byte, input last_of_run,
                    output ready);
endinterface

// ----- design/crcf_crc_unit.sv -----
// Shared CRC-8 accumulator (poly 0x07, init 0, no reflection), one byte per cycle while enabled.
// Depends on crcf_pkg for the polynomial and the control struct.
module crcf_crc_unit import crcf_pkg::*; (
    input  logic       i_clk,
    input  t_crc_ctrl  i_ctrl,
    input  logic [7:0] i_data,
    output logic [7:0] o_crc
);

    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic [7:0] v;

    // Fold one byte into the running CRC, eight bit steps
    always_comb begin
        v = r_crc ^ i_data;
        for (int b = 0; b < 8; b++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        if (i_ctrl.clr) begin
            n_crc = 8'h00;
        end else if (i_ctrl.en) begin
            n_crc = v;
        end else begin
            n_crc = r_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_crc = r_crc;

endmodule

// ----- design/crc8_framed_command_finder.sv -----
// Framed CRC-8 command finder: sliding packet window, header/footer/CRC test, packet or not-found emit.
// A byte that cannot complete a command is taken in S_IDLE; a candidate window clears the shared
// byte-wide CRC unit, folds window bytes 0 to PKT_LEN-3 into it in S_CRC, compares the CRC with
// byte PKT_LEN-2 in S_CHECK, then gives PKT_LEN result beats (held under output stall) from S_EMIT;
// a not-found beat comes from S_MISS. Reset (synchronous, active low) clears the sequencer, fill
// count, match flag and output valid. Depends on crcf_pkg, crcf_if and crcf_crc_unit.
module crc8_framed_command_finder import crcf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    crcf_in_if.sink         i_in,
    crcf_out_if.source      o_out
);

    t_state              r_state, n_state;
    logic [7:0]          r_win [PKT_LEN];
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                r_matched, n_matched;
    logic                r_end, n_end;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_ovalid, n_ovalid;
    logic                r_ofound, n_ofound;
    logic [7:0]          r_obyte, n_obyte;
    logic                r_olast, n_olast;

    logic                acc;
    logic                shift_en;
    logic                can_load;
    logic [FILL_W-1:0]   fill_inc;
    logic                frame_ok;
    t_crc_ctrl           crc_ctrl;
    logic [7:0]          crc_val;

    assign acc      = i_in.valid && i_in.ready;
    assign can_load = !r_ovalid || o_out.ready;
    assign shift_en = acc && !r_matched;
    assign fill_inc = (r_fill < FILL_W'(PKT_LEN)) ? r_fill + 1'b1 : r_fill;

    // Header and footer of the window as it stands after this byte shifts in
    assign frame_ok = (r_win[1] == HDR_FIRST) && (r_win[2] == HDR_SECOND) &&
                      (i_in.rx_byte == FOOTER_BYTE);

    crcf_crc_unit u_crc (
        .i_clk  (i_clk),
        .i_ctrl (crc_ctrl),
        .i_data (r_win[r_idx]),
        .o_crc  (crc_val)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_matched = r_matched;
        n_end     = r_end;
        n_idx     = r_idx;
        n_ofound  = r_ofound;
        n_obyte   = r_obyte;
        n_olast   = r_olast;
        n_ovalid  = o_out.ready ? 1'b0 : r_ovalid;
        crc_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (!r_matched) begin
                        n_fill = fill_inc;
                        if (fill_inc == FILL_W'(PKT_LEN) && frame_ok) begin
                            crc_ctrl.clr = 1'b1;
                            n_idx        = '0;
                            n_end        = i_in.buffer_end;
                            n_state      = S_CRC;
                        end else if (i_in.buffer_end) begin
                            n_fill  = '0;
                            n_state = S_MISS;
                        end
                    end else if (i_in.buffer_end) begin
                        n_matched = 1'b0;
                        n_fill    = '0;
                    end
                end
            end
            S_CRC: begin
                crc_ctrl.en = 1'b1;
                n_idx       = r_idx + 1'b1;
                if (r_idx == IDX_W'(PKT_LEN - 3)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (crc_val == r_win[PKT_LEN-2]) begin
                    n_matched = 1'b1;
                    n_idx     = '0;
                    n_state   = S_EMIT;
                end else if (r_end) begin
                    n_fill  = '0;
                    n_state = S_MISS;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    n_ofound = 1'b1;
                    n_obyte  = r_win[r_idx];
                    n_olast  = (r_idx == IDX_W'(PKT_LEN - 1));
                    n_idx    = r_idx + 1'b1;
                    if (r_idx == IDX_W'(PKT_LEN - 1)) begin
                        n_state = S_IDLE;
                        if (r_end) begin
                            n_matched = 1'b0;
                            n_fill    = '0;
                        end
                    end
                end
            end
            S_MISS: begin
                if (can_load) begin
                    n_ovalid = 1'b1;
                    n_ofound = 1'b0;
                    n_obyte  = 8'h00;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_matched <= 1'b0;
            r_end     <= 1'b0;
            r_idx     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_matched <= n_matched;
            r_end     <= n_end;
            r_idx     <= n_idx;
            r_ovalid  <= n_ovalid;
        end
    end

    // Payload registers: window shift line and output beat
    always_ff @(posedge i_clk) begin
        if (shift_en) begin
            for (int i = 0; i < PKT_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[PKT_LEN-1] <= i_in.rx_byte;
        end
        r_ofound <= n_ofound;
        r_obyte  <= n_obyte;
        r_olast  <= n_olast;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.found       = r_ofound;
    assign o_out.packet_byte = r_obyte;
    assign o_out.last_of_run = r_olast;

    // A not-found beat always closes its run and carries a zero byte
    a_miss_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.found |-> o_out.last_of_run && (o_out.packet_byte == 8'h00))
        else $error("not-found beat malformed");

    // Fill count saturates at the packet length
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(PKT_LEN))
        else $error("fill count overflow");

    // A match only exists on a full window
    a_match_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_matched |-> r_fill == FILL_W'(PKT_LEN))
        else $error("match flag set on partial window");

    // An accepted input never arrives while a packet is being emitted
    a_emit_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == S_EMIT) && r_state == S_EMIT |-> !acc)
        else $error("input accepted during emit");

endmodule
